[design/count_windows_at_most_k_distinct_core_assert.svh]
// ---------------------------------------------------------------------------
// count_windows_at_most_k_distinct_core assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef COUNT_WINDOWS_AT_MOST_K_DISTINCT_CORE_ASSERT_SVH
`define COUNT_WINDOWS_AT_MOST_K_DISTINCT_CORE_ASSERT_SVH

// same-cycle implication
`define CWD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cwd_pkg.sv]
// ---------------------------------------------------------------------------
// cwd_pkg
// shared constants and types of the distinct-value window counter
// ---------------------------------------------------------------------------
package cwd_pkg;

  // sizing
  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned VALUE_BITS   = 10;
  localparam int unsigned IN_VAL_BITS  = 10;
  localparam int unsigned STORE_AW     = $clog2(MAX_LEN);
  localparam int unsigned RIGHT_BITS   = $clog2(MAX_LEN + 1);
  localparam int unsigned TABLE_DEPTH  = 1 << VALUE_BITS;
  localparam int unsigned TOTAL_BITS   = 20;
  localparam int unsigned OUT_LEN_BITS = 11;
  localparam int unsigned CFG_BITS     = 11;
  localparam int unsigned APB_DW       = 32;
  localparam int unsigned APB_AW       = 3;

  // register map
  localparam logic       REG_MAX_DISTINCT   = 1'b0;
  localparam logic [CFG_BITS-1:0] MAX_DISTINCT_RST = CFG_BITS'(2);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ADD   = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_SWEEP = 7'b1000000
  } state_e;

endpackage

[design/count_windows_at_most_k_distinct_core.sv]
// ---------------------------------------------------------------------------
// count_windows_at_most_k_distinct_core
// sliding-window count of subarrays with at most max_distinct distinct values
// ---------------------------------------------------------------------------
// one transaction at a time: input stalls until its result is handed off;
//   each element leaving the window costs a read-modify-write turn of the
//   occurrence table ram; a dropped element (window store full) skips the table
// a last transaction adds a sweep that zeroes the table entries of the window
// reset: a clearing pass over the occurrence table, input stalled
`include "count_windows_at_most_k_distinct_core_assert.svh"

module count_windows_at_most_k_distinct_core
  import cwd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IN_VAL_BITS-1:0]  value_i,
  input  logic                    last_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TOTAL_BITS-1:0]   total_o,
  output logic [OUT_LEN_BITS-1:0] window_length_o,
  output logic                    dropped_o,
  output logic                    is_last_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  state_e                  state_q, state_d;
  logic [CFG_BITS-1:0]     max_q;
  logic [RIGHT_BITS-1:0]   left_q, left_d, right_q, right_d;
  logic [RIGHT_BITS-1:0]   distinct_q, distinct_d;
  logic [TOTAL_BITS-1:0]   total_q, total_d;
  logic [VALUE_BITS-1:0]   val_q, old_q, clr_q;
  logic                    last_q, drop_q, sw_pend_q, sw_pend_d;

  logic                    out_valid_q;
  logic [TOTAL_BITS-1:0]   out_total_q;
  logic [OUT_LEN_BITS-1:0] out_len_q;
  logic                    out_drop_q, out_last_q;

  logic                    in_acc, emit_ok, out_load, shrink, cfg_we;
  logic [RIGHT_BITS-1:0]   len;
  logic [TOTAL_BITS:0]     sum;
  logic [TOTAL_BITS-1:0]   total_new;

  // memory ports
  logic                    st_we;
  logic [STORE_AW-1:0]     st_raddr;
  logic [VALUE_BITS-1:0]   st_rdata;
  logic                    oc_we;
  logic [VALUE_BITS-1:0]   oc_waddr, oc_raddr;
  logic [RIGHT_BITS-1:0]   oc_wdata, oc_rdata;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_MAX_DISTINCT);
  assign prdata = (paddr[2] == REG_MAX_DISTINCT) ? APB_DW'(max_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_DISTINCT_RST;
    end else if (cfg_we) begin
      max_q <= pwdata[CFG_BITS-1:0];
    end
  end

  // handshake and shared datapath
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign emit_ok    = ~out_valid_q | ~out_stall_i;
  assign len        = right_q - left_q;
  assign sum        = {1'b0, total_q} + (TOTAL_BITS + 1)'(len);
  assign total_new  = drop_q ? total_q : (sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0]);
  assign shrink     = (32'(distinct_q) > 32'(max_q)) && (left_q < right_q);
  assign out_load   = emit_ok && ((state_q == S_EMIT) || ((state_q == S_CHECK) && !shrink));

  // window store: written at accept, read at the left edge
  assign st_we    = in_acc && (right_q != RIGHT_BITS'(MAX_LEN));
  assign st_raddr = (state_q == S_DEC) ? STORE_AW'(left_q + 1'b1) : left_q[STORE_AW-1:0];

  cwd_ram #(
    .WIDTH    (VALUE_BITS),
    .ADDR_BITS(STORE_AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(right_q[STORE_AW-1:0]),
    .wdata_i(value_i[VALUE_BITS-1:0]),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // occurrence table: read at accept and on a shrink check
  assign oc_raddr = (state_q == S_CHECK) ? st_rdata : value_i[VALUE_BITS-1:0];

  always_comb begin
    oc_we    = 1'b0;
    oc_waddr = val_q;
    oc_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        oc_we    = 1'b1;
        oc_waddr = clr_q;
      end
      S_ADD: begin
        oc_we    = 1'b1;
        oc_wdata = oc_rdata + 1'b1;
      end
      S_DEC: begin
        oc_we    = (oc_rdata != '0);
        oc_waddr = old_q;
        oc_wdata = oc_rdata - 1'b1;
      end
      S_SWEEP: begin
        oc_we    = sw_pend_q;
        oc_waddr = st_rdata;
      end
      default: ;
    endcase
  end

  cwd_ram #(
    .WIDTH    (RIGHT_BITS),
    .ADDR_BITS(VALUE_BITS)
  ) u_occ (
    .clk_i  (clk_i),
    .we_i   (oc_we),
    .waddr_i(oc_waddr),
    .wdata_i(oc_wdata),
    .raddr_i(oc_raddr),
    .rdata_o(oc_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    left_d     = left_q;
    right_d    = right_q;
    distinct_d = distinct_q;
    total_d    = total_q;
    sw_pend_d  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (right_q == RIGHT_BITS'(MAX_LEN)) ? S_EMIT : S_ADD;
        end
      end
      S_ADD: begin
        right_d = right_q + 1'b1;
        if (oc_rdata == '0) begin
          distinct_d = distinct_q + 1'b1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (shrink) begin
          state_d = S_DEC;
        end else if (!emit_ok) begin
          state_d = S_EMIT;
        end
      end
      S_DEC: begin
        left_d = left_q + 1'b1;
        if (oc_rdata == RIGHT_BITS'(1)) begin
          distinct_d = distinct_q - 1'b1;
        end
        state_d = S_CHECK;
      end
      S_SWEEP: begin
        // one window entry read per cycle, its table entry zeroed in the cycle after
        if (left_q < right_q) begin
          left_d    = left_q + 1'b1;
          sw_pend_d = 1'b1;
        end else if (!sw_pend_q) begin
          left_d     = '0;
          right_d    = '0;
          distinct_d = '0;
          total_d    = '0;
          state_d    = S_IDLE;
        end
      end
      default: ;
    endcase
    // result hand-off ends every item
    if (out_load) begin
      total_d = total_new;
      state_d = last_q ? S_SWEEP : S_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      left_q     <= '0;
      right_q    <= '0;
      distinct_q <= '0;
      total_q    <= '0;
      sw_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      left_q     <= left_d;
      right_q    <= right_d;
      distinct_q <= distinct_d;
      total_q    <= total_d;
      sw_pend_q  <= sw_pend_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= value_i[VALUE_BITS-1:0];
      last_q <= last_i;
      drop_q <= (right_q == RIGHT_BITS'(MAX_LEN));
    end
    if ((state_q == S_CHECK) && shrink) begin
      old_q <= st_rdata;
    end
    if (out_load) begin
      out_total_q <= total_new;
      out_len_q   <= OUT_LEN_BITS'(len);
      out_drop_q  <= drop_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_o         = out_total_q;
  assign window_length_o = out_len_q;
  assign dropped_o       = out_drop_q;
  assign is_last_o       = out_last_q;

  // checks, the sweep walks the left edge up without touching the count
  `CWD_ASSERT(a_window_order, 1'b1, left_q <= right_q, "left edge passed right edge")
  `CWD_ASSERT(a_distinct_ok, out_load && !drop_q, distinct_q <= max_q, "distinct limit exceeded")
  `CWD_ASSERT(a_distinct_bound, state_q != S_SWEEP, distinct_q <= len, "too many distinct values")
  `CWD_ASSERT_NEXT(a_last_sweeps, out_load && last_q, state_q == S_SWEEP, "no sweep after last")

endmodule

[design/cwd_ram.sv]
// ---------------------------------------------------------------------------
// cwd_ram
// simple dual-port synchronous ram, one write and one registered read port
// ---------------------------------------------------------------------------
module cwd_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned ADDR_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [(1 << ADDR_BITS)];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
